/* src/bea_pkg.sv */
// Package for the bitmap extent allocator: request and result types,
// field widths, sequencer states and shared constants. No dependencies.
package bea_pkg;

  localparam int FIELD_W     = 6;
  localparam int DEF_BLOCKS  = 32;
  localparam int MAX_RESULTS = 16;
  localparam int EXT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [FIELD_W-1:0] block_count;
    logic [FIELD_W-1:0] free_start;
    logic [FIELD_W-1:0] free_end;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] extent_first;
    logic [FIELD_W-1:0] extent_end;
    logic               ok;
    logic               last;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_START,
    ST_SCAN_END,
    ST_RESPOND
  } state_t;

endpackage

/* src/bea_ffs.sv */
// Find-first-set encoder shared by the allocator sequencer.
// Reports the lowest set bit of the input vector. Uses no package items.
module bea_ffs #(
  parameter int W = 32
) (
  input  logic [W-1:0]         vec,
  output logic                 found,
  output logic [$clog2(W)-1:0] idx
);

  localparam int IDX_W = $clog2(W);

  always_comb begin
    found = |vec;
    idx   = '0;
    // Scan from the top so that the lowest set bit wins.
    for (int i = W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

endmodule

/* src/bitmap_extent_allocator_unit.sv */
// Top level of the bitmap extent allocator: used-block bitmap, scan
// sequencer and result register. Depends on bea_pkg and bea_ffs.
//
// Usage: a request enters on req (req_valid/req_ready). An allocate request
// (mode 0) asks for block_count blocks; the block answers on rsp
// (rsp_valid/rsp_ready) with one result per contiguous extent taken, lowest
// first, the final one marked by last. If too few blocks are free, or the
// allocation would need more than MAX_RESULTS extents, one result with ok=0
// is sent and the bitmap is left alone. A zero block_count gives one ok
// result and changes nothing. A free request (mode 1) clears the blocks in
// [free_start, free_end) and always answers with one ok result.
// Sequence: one request is worked at a time. For an allocate request the
// shared find-first encoder runs a dry pass (a start step, then an end step
// for each extent) to check space, then the same walk again while the
// results are sent. A shortage is found within the dry pass. A free
// request goes straight to the respond state.
// Reset clears the bitmap so that every block is free and drops any pending
// result. When the receiver stalls, the result register holds its value and
// the scan pauses until that result is taken; a new request is accepted as
// soon as the final result has been loaded, even if it still waits.
module bitmap_extent_allocator_unit #(
  parameter int BLOCKS = bea_pkg::DEF_BLOCKS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bea_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bea_pkg::rsp_t rsp
);

  import bea_pkg::*;

  localparam int IDX_W = $clog2(BLOCKS);
  localparam int POS_W = $clog2(BLOCKS + 1);
  localparam int SUM_W = ((POS_W > FIELD_W) ? POS_W : FIELD_W) + 1;

  // Control state.
  state_t            state, state_next;
  logic              rsp_valid_r, rsp_valid_next;
  logic [BLOCKS-1:0] block_used, block_used_next;

  // Working registers of the current request.
  logic               commit, commit_next;
  logic [BLOCKS-1:0]  scratch, scratch_next;
  logic [FIELD_W-1:0] remaining, remaining_next;
  logic [FIELD_W-1:0] count, count_next;
  logic [EXT_W-1:0]   ext_count, ext_count_next;
  logic [IDX_W-1:0]   start, start_next;
  logic               mode, mode_next;
  logic [FIELD_W-1:0] free_start, free_start_next;
  logic [FIELD_W-1:0] free_end, free_end_next;
  logic               resp_ok, resp_ok_next;
  rsp_t               rsp_r, rsp_next;

  // Shared encoder and extent arithmetic.
  logic [BLOCKS-1:0]  ffs_vec;
  logic               ffs_found;
  logic [IDX_W-1:0]   ffs_idx;
  logic [POS_W-1:0]   run_end;
  logic [SUM_W-1:0]   cap;
  logic [POS_W-1:0]   ext_end;
  logic [FIELD_W-1:0] rem_after;
  logic [BLOCKS-1:0]  ext_mask;
  logic [BLOCKS-1:0]  free_mask;
  logic               out_free;

  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = rsp_valid_r;
  assign rsp       = rsp_r;
  assign out_free  = !rsp_valid_r || rsp_ready;

  // In the start step the encoder looks for the first free block; in the end
  // step it looks for the first used block at or above the run start.
  always_comb begin
    for (int i = 0; i < BLOCKS; i++) begin
      if (state == ST_SCAN_START) begin
        ffs_vec[i] = !scratch[i];
      end else begin
        ffs_vec[i] = scratch[i] && (IDX_W'(i) >= start);
      end
    end
  end

  bea_ffs #(
    .W(BLOCKS)
  ) u_ffs (
    .vec  (ffs_vec),
    .found(ffs_found),
    .idx  (ffs_idx)
  );

  // The extent ends at the end of the free run or when the request is
  // satisfied, whichever comes first.
  always_comb begin
    run_end   = ffs_found ? POS_W'(ffs_idx) : POS_W'(BLOCKS);
    cap       = SUM_W'(start) + SUM_W'(remaining);
    ext_end   = (SUM_W'(run_end) <= cap) ? run_end : POS_W'(cap);
    rem_after = remaining - FIELD_W'(ext_end - POS_W'(start));
    for (int i = 0; i < BLOCKS; i++) begin
      ext_mask[i]  = (IDX_W'(i) >= start) && (POS_W'(i) < ext_end);
      free_mask[i] = (SUM_W'(i) >= SUM_W'(free_start)) &&
                     (SUM_W'(i) < SUM_W'(free_end));
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.mode == MODE_FREE || req.block_count == '0) begin
            state_next = ST_RESPOND;
          end else begin
            state_next = ST_SCAN_START;
          end
        end
      end
      ST_SCAN_START: begin
        if (!ffs_found) begin
          state_next = ST_RESPOND;
        end else if (!commit && ext_count == EXT_W'(MAX_RESULTS)) begin
          state_next = ST_RESPOND;
        end else begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        if (!commit || out_free) begin
          if (rem_after == '0 && commit) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_SCAN_START;
          end
        end
      end
      ST_RESPOND: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Register updates.
  always_comb begin
    rsp_valid_next  = rsp_valid_r && !rsp_ready;
    block_used_next = block_used;
    commit_next     = commit;
    scratch_next    = scratch;
    remaining_next  = remaining;
    count_next      = count;
    ext_count_next  = ext_count;
    start_next      = start;
    mode_next       = mode;
    free_start_next = free_start;
    free_end_next   = free_end;
    resp_ok_next    = resp_ok;
    rsp_next        = rsp_r;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          mode_next       = req.mode;
          count_next      = req.block_count;
          remaining_next  = req.block_count;
          free_start_next = req.free_start;
          free_end_next   = req.free_end;
          scratch_next    = block_used;
          commit_next     = 1'b0;
          ext_count_next  = '0;
          resp_ok_next    = 1'b1;
        end
      end
      ST_SCAN_START: begin
        if (!ffs_found) begin
          resp_ok_next = 1'b0;
        end else if (!commit && ext_count == EXT_W'(MAX_RESULTS)) begin
          resp_ok_next = 1'b0;
        end else begin
          start_next = ffs_idx;
        end
      end
      ST_SCAN_END: begin
        if (!commit || out_free) begin
          scratch_next   = scratch | ext_mask;
          remaining_next = rem_after;
          ext_count_next = ext_count + 1'b1;
          if (commit) begin
            rsp_valid_next        = 1'b1;
            rsp_next.extent_first = FIELD_W'(start);
            rsp_next.extent_end   = FIELD_W'(ext_end);
            rsp_next.ok           = 1'b1;
            rsp_next.last         = (rem_after == '0);
            if (rem_after == '0) begin
              block_used_next = scratch | ext_mask;
            end
          end else if (rem_after == '0) begin
            // The dry pass fit; replay the same walk and send the extents.
            commit_next    = 1'b1;
            scratch_next   = block_used;
            remaining_next = count;
            ext_count_next = '0;
          end
        end
      end
      ST_RESPOND: begin
        if (out_free) begin
          rsp_valid_next        = 1'b1;
          rsp_next.extent_first = '0;
          rsp_next.extent_end   = '0;
          rsp_next.ok           = resp_ok;
          rsp_next.last         = 1'b1;
          if (mode == MODE_FREE) begin
            block_used_next = block_used & ~free_mask;
          end
        end
      end
      default: begin
        rsp_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rsp_valid_r <= 1'b0;
      block_used  <= '0;
    end else begin
      state       <= state_next;
      rsp_valid_r <= rsp_valid_next;
      block_used  <= block_used_next;
    end
  end

  always_ff @(posedge clk) begin
    commit     <= commit_next;
    scratch    <= scratch_next;
    remaining  <= remaining_next;
    count      <= count_next;
    ext_count  <= ext_count_next;
    start      <= start_next;
    mode       <= mode_next;
    free_start <= free_start_next;
    free_end   <= free_end_next;
    resp_ok    <= resp_ok_next;
    rsp_r      <= rsp_next;
  end

endmodule
